FILE: rtl/rcpd_pkg.sv
// ----------------------------------------------------------------------------
// rcpd_pkg
// Shared types and constants for the RC pulse decoder with centre deadzone.
// ----------------------------------------------------------------------------
package rcpd_pkg;

    localparam int COUNTER_BITS_DEF  = 32;
    localparam int OUT_FRAC_BITS_DEF = 14;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int WIDTH_W    = 16;
    localparam int CMD_W      = 16;
    localparam int TIMEOUT_W  = 32;

    localparam logic [15:0] PULSE_MIN_RST = 16'd1000;
    localparam logic [15:0] PULSE_MAX_RST = 16'd2000;
    localparam logic [14:0] DEADZONE_RST  = 15'd50;
    localparam logic [31:0] TIMEOUT_RST   = 32'd50000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_MIN = 2'd0,
        REG_PULSE_MAX = 2'd1,
        REG_DEADZONE  = 2'd2,
        REG_TIMEOUT   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0] pulse_min;
        logic [15:0] pulse_max;
        logic [14:0] deadzone;
    } t_map_cfg;

    typedef struct packed {
        logic               start;
        logic               ack;
        logic [WIDTH_W-1:0] width;
    } t_lane_ctl;

    typedef struct packed {
        logic             done;
        logic [CMD_W-1:0] cmd;
    } t_lane_stat;

endpackage

FILE: rtl/rcpd_lane.sv
// ----------------------------------------------------------------------------
// rcpd_lane
// One channel of the width-to-command mapping: deadzone classification and a
// bit-serial restoring divider giving a signed Q1.F command.
// ----------------------------------------------------------------------------
module rcpd_lane #(
    parameter int OUT_FRAC_BITS = rcpd_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rcpd_pkg::t_map_cfg   i_cfg,
    input  rcpd_pkg::t_lane_ctl  i_ctl,
    output rcpd_pkg::t_lane_stat o_stat
);

    localparam int RW = OUT_FRAC_BITS + 2;
    localparam int CW = $clog2(OUT_FRAC_BITS + 1);
    localparam logic signed [RW-1:0] ONE_Q = RW'(64'd1 << OUT_FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_lane_state;

    t_lane_state r_state, n_state;
    logic [15:0]              r_rem, n_rem;
    logic [15:0]              r_div, n_div;
    logic [OUT_FRAC_BITS-1:0] r_quo, n_quo;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic                     r_neg, n_neg;
    logic [15:0]              r_cmd, n_cmd;

    logic signed [18:0] s_x2, s_mean2, s_dz2, s_lo2, s_span, s_up_num, s_dn_num;
    logic               s_up, s_dn, s_divide;
    logic signed [RW-1:0] s_bypass, s_res;
    logic signed [31:0]   s_bypass_ext, s_res_ext;
    logic [16:0]          s_rem_sh;
    logic                 s_ge;

    // classification of a new width against the deadzone
    always_comb begin
        s_x2     = signed'({2'b00, i_ctl.width, 1'b0});
        s_lo2    = signed'({2'b00, i_cfg.pulse_min, 1'b0});
        s_mean2  = signed'({3'b000, i_cfg.pulse_min}) + signed'({3'b000, i_cfg.pulse_max});
        s_dz2    = signed'({3'b000, i_cfg.deadzone, 1'b0});
        s_span   = signed'({3'b000, i_cfg.pulse_max}) - signed'({3'b000, i_cfg.pulse_min})
                   - s_dz2;
        s_up_num = s_x2 - s_mean2 - s_dz2;
        s_dn_num = s_x2 - s_lo2;
        s_up     = s_x2 > (s_mean2 + s_dz2);
        s_dn     = s_x2 < (s_mean2 - s_dz2);
        s_divide = 1'b0;
        s_bypass = '0;
        if (s_up) begin
            if (s_span <= 0 || s_up_num >= s_span) begin
                s_bypass = ONE_Q;
            end else begin
                s_divide = 1'b1;
            end
        end else if (s_dn) begin
            if (s_span <= 0 || i_ctl.width <= i_cfg.pulse_min) begin
                s_bypass = -ONE_Q;
            end else begin
                s_divide = 1'b1;
            end
        end
        s_bypass_ext = 32'(s_bypass);
    end

    // one quotient bit per cycle; numerator is below the divisor, so the
    // quotient never exceeds F bits
    always_comb begin
        s_rem_sh  = {r_rem, 1'b0};
        s_ge      = s_rem_sh >= {1'b0, r_div};
        s_res     = r_neg ? signed'({2'b00, r_quo}) - ONE_Q : signed'({2'b00, r_quo});
        s_res_ext = 32'(s_res);
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_cmd   = r_cmd;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_rem = s_up ? s_up_num[15:0] : s_dn_num[15:0];
                    n_div = s_span[15:0];
                    n_neg = s_dn;
                    n_quo = '0;
                    n_cnt = CW'(OUT_FRAC_BITS);
                    n_cmd = s_bypass_ext[15:0];
                    n_state = s_divide ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_cmd   = s_res_ext[15:0];
                    n_state = S_DONE;
                end else begin
                    n_rem = s_ge ? 16'(s_rem_sh - {1'b0, r_div}) : s_rem_sh[15:0];
                    n_quo = {r_quo[OUT_FRAC_BITS-2:0], s_ge};
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_DONE: begin
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_cmd <= n_cmd;
    end

    assign o_stat.done = (r_state == S_DONE);
    assign o_stat.cmd  = r_cmd;

endmodule

FILE: rtl/rc_pulse_decoder_deadzone_core.sv
// Flow: a width that needs division passes lane states S_IDLE, S_DIV and
//   S_DONE, then the output register; deadzone and clamped widths skip S_DIV.
// Handshake: the input stalls until both lane results are merged into the
//   output register; each lane holds a bit-serial restoring divider (one quotient bit a cycle).
// Reset: synchronous, active low; counters, timestamps, widths and levels
//   clear, configuration returns to 1000 / 2000 / 50 / 50000.
// ----------------------------------------------------------------------------
// rc_pulse_decoder_deadzone_core
// RC pulse width receiver: edge timestamps, width capture, two mapping lanes
// for steering and throttle, and a merge stage with the mode timeout flag.
// ----------------------------------------------------------------------------
module rc_pulse_decoder_deadzone_core #(
    parameter int COUNTER_BITS  = rcpd_pkg::COUNTER_BITS_DEF,
    parameter int OUT_FRAC_BITS = rcpd_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rcpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_steering_level,
    input  logic                               i_throttle_level,
    input  logic                               i_mode_level,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [rcpd_pkg::CMD_W-1:0]  o_steering_cmd,
    output logic signed [rcpd_pkg::CMD_W-1:0]  o_throttle_cmd,
    output logic                               o_auto_mode
);

    localparam int CB   = COUNTER_BITS;
    localparam int CMPW = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;
    localparam logic [CB-1:0] SAT_MAX = CB'(32'h0000_FFFF);

    rcpd_pkg::t_map_cfg r_map_cfg;
    logic [rcpd_pkg::TIMEOUT_W-1:0] r_timeout;

    logic [CB-1:0] r_tick, r_steer_rise, r_thr_rise, r_mode_rise;
    logic [CB-1:0] n_steer_rise, n_thr_rise, n_mode_rise;
    logic [15:0]   r_steer_w, r_thr_w, n_steer_w, n_thr_w;
    logic [2:0]    r_prev, s_lv, s_rise, s_fall;
    logic [CB-1:0] s_steer_age, s_thr_age, s_mode_age;
    logic          s_auto;

    logic r_busy, r_auto;
    logic r_out_valid, r_out_auto;
    logic [15:0] r_out_steer, r_out_thr;

    logic s_in_acc, s_load;
    rcpd_pkg::t_lane_ctl  s_steer_ctl, s_thr_ctl;
    rcpd_pkg::t_lane_stat s_steer_stat, s_thr_stat;

    assign s_in_acc = i_in_valid && !r_busy;
    assign s_load   = s_steer_stat.done && s_thr_stat.done && (!r_out_valid || !i_out_stall);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cfg.pulse_min <= rcpd_pkg::PULSE_MIN_RST;
            r_map_cfg.pulse_max <= rcpd_pkg::PULSE_MAX_RST;
            r_map_cfg.deadzone  <= rcpd_pkg::DEADZONE_RST;
            r_timeout           <= rcpd_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (rcpd_pkg::t_cfg_reg'(i_cfg_idx))
                rcpd_pkg::REG_PULSE_MIN: r_map_cfg.pulse_min <= i_cfg_data[15:0];
                rcpd_pkg::REG_PULSE_MAX: r_map_cfg.pulse_max <= i_cfg_data[15:0];
                rcpd_pkg::REG_DEADZONE:  r_map_cfg.deadzone  <= i_cfg_data[14:0];
                rcpd_pkg::REG_TIMEOUT:   r_timeout           <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // edge detection and width capture for the current tick
    always_comb begin
        s_lv        = {i_mode_level, i_throttle_level, i_steering_level};
        s_rise      = s_lv & ~r_prev;
        s_fall      = r_prev & ~s_lv;
        s_steer_age = r_tick - r_steer_rise;
        s_thr_age   = r_tick - r_thr_rise;

        n_steer_rise = s_rise[0] ? r_tick : r_steer_rise;
        n_thr_rise   = s_rise[1] ? r_tick : r_thr_rise;
        n_mode_rise  = s_rise[2] ? r_tick : r_mode_rise;

        n_steer_w = r_steer_w;
        if (!s_rise[0] && s_fall[0]) begin
            n_steer_w = (s_steer_age > SAT_MAX) ? 16'hFFFF : s_steer_age[15:0];
        end
        n_thr_w = r_thr_w;
        if (!s_rise[1] && s_fall[1]) begin
            n_thr_w = (s_thr_age > SAT_MAX) ? 16'hFFFF : s_thr_age[15:0];
        end

        s_mode_age = r_tick - n_mode_rise;
        s_auto     = CMPW'(s_mode_age) > CMPW'(r_timeout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_steer_rise <= '0;
            r_thr_rise   <= '0;
            r_mode_rise  <= '0;
            r_steer_w    <= '0;
            r_thr_w      <= '0;
            r_prev       <= '0;
        end else if (s_in_acc) begin
            r_tick       <= r_tick + CB'(1);
            r_steer_rise <= n_steer_rise;
            r_thr_rise   <= n_thr_rise;
            r_mode_rise  <= n_mode_rise;
            r_steer_w    <= n_steer_w;
            r_thr_w      <= n_thr_w;
            r_prev       <= s_lv;
        end
    end

    assign s_steer_ctl.start = s_in_acc;
    assign s_steer_ctl.ack   = s_load;
    assign s_steer_ctl.width = n_steer_w;
    assign s_thr_ctl.start   = s_in_acc;
    assign s_thr_ctl.ack     = s_load;
    assign s_thr_ctl.width   = n_thr_w;

    rcpd_lane #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_lane_steer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_map_cfg),
        .i_ctl   (s_steer_ctl),
        .o_stat  (s_steer_stat)
    );

    rcpd_lane #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_lane_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_map_cfg),
        .i_ctl   (s_thr_ctl),
        .o_stat  (s_thr_stat)
    );

    // merge: both lanes finished and the output register free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_in_acc) begin
                r_busy <= 1'b1;
            end else if (s_load) begin
                r_busy <= 1'b0;
            end
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_auto <= s_auto;
        end
        if (s_load) begin
            r_out_steer <= s_steer_stat.cmd;
            r_out_thr   <= s_thr_stat.cmd;
            r_out_auto  <= r_auto;
        end
    end

    assign o_in_stall     = r_busy;
    assign o_out_valid    = r_out_valid;
    assign o_steering_cmd = signed'(r_out_steer);
    assign o_throttle_cmd = signed'(r_out_thr);
    assign o_auto_mode    = r_out_auto;

endmodule

FILE: rtl/rcpd_checker.sv
// ----------------------------------------------------------------------------
// rcpd_checker
// Port-level checks on the RC pulse decoder core, bound to the top level.
// ----------------------------------------------------------------------------
module rcpd_checker #(
    parameter int OUT_FRAC_BITS = rcpd_pkg::OUT_FRAC_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [rcpd_pkg::CMD_W-1:0]  o_steering_cmd,
    input logic signed [rcpd_pkg::CMD_W-1:0]  o_throttle_cmd
);

    // a result waiting on the consumer stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // each accepted transaction blocks the input until its result is merged
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // the input frees only when a result lands in the output register
    a_free_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("input freed without a result");

    // commands never exceed full scale at the default fraction width
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (OUT_FRAC_BITS > 14) ||
            (o_steering_cmd >= -16'sd16384 && o_steering_cmd <= 16'sd16384 &&
             o_throttle_cmd >= -16'sd16384 && o_throttle_cmd <= 16'sd16384))
        else $error("command beyond full scale");

endmodule

bind rc_pulse_decoder_deadzone_core rcpd_checker #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_rcpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_steering_cmd (o_steering_cmd),
    .o_throttle_cmd (o_throttle_cmd)
);

FILE: tb/rc_pulse_decoder_deadzone_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_pulse_decoder_deadzone_core_test
// Drives microsecond ticks of steering, throttle and mode pin levels into the
// decoder and keeps its own copy of the tick counter, edge timestamps, stored
// widths and mapping registers. Every tick transaction yields one expected
// command set, compared field by field with what the block returns.
// Directed ticks cover the mapping regions, degenerate and reversed ranges,
// register extremes, the mode timeout and a held pulse; random pulse trains
// and pin noise follow under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module rc_pulse_decoder_deadzone_core_test;

    localparam int     OUT_FRAC      = rcpd_pkg::OUT_FRAC_BITS_DEF;
    localparam longint FULL_SCALE    = longint'(1) << OUT_FRAC;
    localparam int     SETTLE_CYCLES = OUT_FRAC + 10;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     LONG_PULSE    = 30;

    typedef struct {
        logic signed [rcpd_pkg::CMD_W-1:0] steer;
        logic signed [rcpd_pkg::CMD_W-1:0] throttle;
        logic                              auto_flag;
    } t_tick_cmds;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rcpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rcpd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_steering_level;
    logic                            i_throttle_level;
    logic                            i_mode_level;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic signed [rcpd_pkg::CMD_W-1:0] o_steering_cmd;
    logic signed [rcpd_pkg::CMD_W-1:0] o_throttle_cmd;
    logic                            o_auto_mode;

    // Mirror of the mapping registers and decoder state
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;
    logic [14:0] cfg_dz;
    logic [31:0] cfg_timeout;
    logic [31:0] tick_now;
    logic [31:0] steer_rise_t;
    logic [31:0] throttle_rise_t;
    logic [31:0] mode_rise_t;
    logic [15:0] steer_width;
    logic [15:0] throttle_width;
    logic [2:0]  prev_pins;

    t_tick_cmds  pending_cmds[$];
    int unsigned error_count;
    bit          gaps_on;
    bit          stall_on;
    bit          sink_hold;
    int          stall_left;
    int          hold_count;

    rc_pulse_decoder_deadzone_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_steering_level (i_steering_level),
        .i_throttle_level (i_throttle_level),
        .i_mode_level     (i_mode_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_steering_cmd   (o_steering_cmd),
        .o_throttle_cmd   (o_throttle_cmd),
        .o_auto_mode      (o_auto_mode)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [15:0] clip_width(input logic [31:0] span);
        return (span > 32'd65535) ? 16'hFFFF : span[15:0];
    endfunction

    // Centred deadzone, then each half scaled linearly onto -1..0 or 0..1
    function automatic logic signed [rcpd_pkg::CMD_W-1:0] map_to_cmd(input logic [15:0] w);
        longint x, lo, hi, dz, m2, span, r;
        x    = w;
        lo   = cfg_min;
        hi   = cfg_max;
        dz   = cfg_dz;
        m2   = lo + hi;
        span = hi - lo - 2 * dz;
        if (2 * x > m2 + 2 * dz) begin
            if (span <= 0) begin
                r = FULL_SCALE;
            end else begin
                r = ((2 * x - m2 - 2 * dz) * FULL_SCALE) / span;
                if (r > FULL_SCALE)
                    r = FULL_SCALE;
            end
        end else if (2 * x < m2 - 2 * dz) begin
            if (span <= 0 || x <= lo) begin
                r = -FULL_SCALE;
            end else begin
                r = ((2 * x - 2 * lo) * FULL_SCALE) / span - FULL_SCALE;
                if (r < -FULL_SCALE)
                    r = -FULL_SCALE;
            end
        end else begin
            r = 0;
        end
        return r[rcpd_pkg::CMD_W-1:0];
    endfunction

    // One tick: edges against the previous levels, widths, then commands
    task automatic decode_tick(input logic [2:0] pins);
        logic [31:0] stamp;
        logic [2:0]  rise;
        logic [2:0]  fall;
        t_tick_cmds  cmds;
        stamp = tick_now;
        rise  = pins & ~prev_pins;
        fall  = prev_pins & ~pins;
        if (rise[0])
            steer_rise_t = stamp;
        else if (fall[0])
            steer_width = clip_width(stamp - steer_rise_t);
        if (rise[1])
            throttle_rise_t = stamp;
        else if (fall[1])
            throttle_width = clip_width(stamp - throttle_rise_t);
        if (rise[2])
            mode_rise_t = stamp;
        prev_pins      = pins;
        cmds.steer     = map_to_cmd(steer_width);
        cmds.throttle  = map_to_cmd(throttle_width);
        cmds.auto_flag = ((stamp - mode_rise_t) > cfg_timeout);
        pending_cmds.push_back(cmds);
        tick_now = stamp + 32'd1;
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_tick(input logic steer, input logic thr, input logic mode);
        int gap;
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_steering_level <= steer;
        i_throttle_level <= thr;
        i_mode_level     <= mode;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        decode_tick({mode, thr, steer});
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input rcpd_pkg::t_cfg_reg idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            rcpd_pkg::REG_PULSE_MIN: cfg_min     = data[15:0];
            rcpd_pkg::REG_PULSE_MAX: cfg_max     = data[15:0];
            rcpd_pkg::REG_DEADZONE:  cfg_dz      = data[14:0];
            rcpd_pkg::REG_TIMEOUT:   cfg_timeout = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mapping(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] dz, input logic [31:0] tmo);
        wait_idle();
        write_reg(rcpd_pkg::REG_PULSE_MIN, lo);
        write_reg(rcpd_pkg::REG_PULSE_MAX, hi);
        write_reg(rcpd_pkg::REG_DEADZONE, dz);
        write_reg(rcpd_pkg::REG_TIMEOUT, tmo);
    endtask

    // Stored widths stay put; one quiet tick shows how they map now
    task automatic probe_map(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] dz);
        set_mapping(lo, hi, dz, cfg_timeout);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    task automatic pick_random_setup();
        logic [31:0] lo, hi, dz, tmo, swap;
        int          r;
        r   = $urandom_range(0, 9);
        lo  = $urandom_range(0, 12);
        hi  = lo + $urandom_range(2, 40);
        dz  = $urandom_range(0, 6);
        tmo = $urandom_range(0, 40);
        if (r == 0) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end else if (r == 1) begin
            dz = (hi - lo) / 2 + $urandom_range(0, 2);
        end
        if ($urandom_range(0, 7) == 0)
            tmo = 32'hFFFF_FFFF;
        set_mapping(lo, hi, dz, tmo);
    endtask

    function automatic int next_run(input int pin, input logic level);
        int reach;
        if (pin == 2) begin
            reach = (cfg_timeout > 32'd50) ? 60 : int'(cfg_timeout) + 10;
            return level ? $urandom_range(1, 4) : $urandom_range(1, reach);
        end
        reach = ((cfg_min > cfg_max) ? int'(cfg_min) : int'(cfg_max)) + 2 * int'(cfg_dz) + 6;
        if (reach > 80)
            reach = 80;
        return level ? $urandom_range(1, reach) : $urandom_range(1, 6);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_map_regions();
        set_mapping(32'd2, 32'd10, 32'd1, 32'd4);
        // steering width 5, throttle width 3
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        probe_map(32'd0, 32'd8, 32'd0);
        probe_map(32'd3, 32'd4, 32'd0);
        probe_map(32'd4, 32'd5, 32'd1);
        probe_map(32'd10, 32'd2, 32'd0);
        probe_map(32'd4, 32'd2, 32'd0);
        // upper data bits beyond the deadzone register are dropped
        probe_map(32'd0, 32'd65535, 32'hFFFF_FFFF);
        probe_map(32'd65535, 32'd65535, 32'd0);
        probe_map(32'd0, 32'd0, 32'd0);
        probe_map(32'd0, 32'd65535, 32'd0);
    endtask

    task automatic test_mode_timeout();
        set_mapping(cfg_min, cfg_max, cfg_dz, 32'd0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        set_mapping(cfg_min, cfg_max, cfg_dz, 32'd3);
        send_tick(1'b0, 1'b0, 1'b1);
        repeat (6) send_tick(1'b0, 1'b0, 1'b0);
        set_mapping(cfg_min, cfg_max, cfg_dz, 32'hFFFF_FFFF);
        repeat (3) send_tick(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_long_pulse();
        // held widths sit below the range, so the pulse runs on the fast path
        set_mapping(32'(rcpd_pkg::PULSE_MIN_RST), 32'(rcpd_pkg::PULSE_MAX_RST),
                    32'(rcpd_pkg::DEADZONE_RST), 32'hFFFF_FFFF);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (LONG_PULSE) send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        // the stored width lands in the upper half, then in the lower half
        probe_map(32'd0, 32'd40, 32'd0);
        probe_map(32'd0, 32'd65535, 32'd0);
    endtask

    task automatic test_random_pulses(input int segments, input int per_segment);
        int          run_left[3];
        logic [2:0]  pins;
        for (int seg = 0; seg < segments; seg++) begin
            pick_random_setup();
            pins = prev_pins;
            for (int p = 0; p < 3; p++)
                run_left[p] = $urandom_range(0, 3);
            for (int n = 0; n < per_segment; n++) begin
                for (int p = 0; p < 3; p++) begin
                    if (run_left[p] == 0) begin
                        pins[p]     = ~pins[p];
                        run_left[p] = next_run(p, pins[p]);
                    end
                    run_left[p]--;
                end
                send_tick(pins[0], pins[1], pins[2]);
            end
        end
    endtask

    task automatic test_pin_noise(input int count);
        logic [2:0] pins;
        pick_random_setup();
        repeat (count) begin
            pins = $urandom_range(0, 7);
            send_tick(pins[0], pins[1], pins[2]);
        end
    endtask

    task automatic test_output_holdoff(input int count);
        logic [2:0] pins;
        pick_random_setup();
        gaps_on   = 1'b0;
        sink_hold = 1'b1;
        repeat (count) begin
            pins = $urandom_range(0, 7);
            send_tick(pins[0], pins[1], pins[2]);
        end
        sink_hold = 1'b0;
        gaps_on   = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall generator and checker
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_hold && hold_count < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_count  = hold_count + 1;
        end else begin
            if (!sink_hold)
                hold_count = 0;
            if (stall_on && stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left  = stall_left - 1;
            end else begin
                i_out_stall <= 1'b0;
                if (stall_on) begin
                    case ($urandom_range(0, 99)) inside
                        [0:69]:  stall_left = 0;
                        [70:92]: stall_left = $urandom_range(1, 3);
                        default: stall_left = $urandom_range(8, 40);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_tick_cmds want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected transaction: steering_cmd %0d throttle_cmd %0d auto_mode %0b",
                       o_steering_cmd, o_throttle_cmd, o_auto_mode);
                error_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_steering_cmd !== want.steer) begin
                    $error("steering_cmd: expected %0d, got %0d", want.steer, o_steering_cmd);
                    error_count++;
                end
                if (o_throttle_cmd !== want.throttle) begin
                    $error("throttle_cmd: expected %0d, got %0d",
                           want.throttle, o_throttle_cmd);
                    error_count++;
                end
                if (o_auto_mode !== want.auto_flag) begin
                    $error("auto_mode: expected %0b, got %0b", want.auto_flag, o_auto_mode);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = rcpd_pkg::REG_PULSE_MIN;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_steering_level = 1'b0;
        i_throttle_level = 1'b0;
        i_mode_level     = 1'b0;
        i_out_stall      = 1'b0;
        cfg_min          = rcpd_pkg::PULSE_MIN_RST;
        cfg_max          = rcpd_pkg::PULSE_MAX_RST;
        cfg_dz           = rcpd_pkg::DEADZONE_RST;
        cfg_timeout      = rcpd_pkg::TIMEOUT_RST;
        tick_now         = '0;
        steer_rise_t     = '0;
        throttle_rise_t  = '0;
        mode_rise_t      = '0;
        steer_width      = '0;
        throttle_width   = '0;
        prev_pins        = '0;
        error_count      = 0;
        gaps_on          = 1'b1;
        stall_on         = 1'b1;
        sink_hold        = 1'b0;
        stall_left       = 0;
        hold_count       = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_map_regions();
        test_mode_timeout();
        test_long_pulse();
        test_random_pulses(6, 50);
        test_pin_noise(50);
        test_output_holdoff(40);
        wait_idle();

        if (error_count == 0 && pending_cmds.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
